@@ rtl/core/plc_pkg.sv @@
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types, codes and helpers for the password lock controller.
// ----------------------------------------------------------------------------
package plc_pkg;

    // Password length default
    localparam int PASS_LEN_DEF = 5;

    // Serial command and reply codes
    localparam logic [7:0] CMD_STATUS  = 8'hE1;
    localparam logic [7:0] CMD_SET     = 8'hE2;
    localparam logic [7:0] ACK_DIGIT   = 8'hE3;
    localparam logic [7:0] CMD_CONFIRM = 8'hE4;
    localparam logic [7:0] RSP_MATCH   = 8'hE5;
    localparam logic [7:0] RSP_NOMATCH = 8'hE6;
    localparam logic [7:0] CMD_CHECK   = 8'hE7;
    localparam logic [7:0] CMD_LOCKOUT = 8'hF0;
    localparam logic [7:0] CMD_UNLOCK  = 8'hF1;
    localparam logic [7:0] RSP_LOCK    = 8'hF2;
    localparam logic [7:0] SAVED_MARK  = 8'h23;
    localparam logic [7:0] ERASED      = 8'hFF;

    // Request types
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;

    // Motor drive codes
    localparam logic [1:0] DIR_STOP  = 2'd0;
    localparam logic [1:0] DIR_OPEN  = 2'd1;
    localparam logic [1:0] DIR_CLOSE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_OPEN_SECONDS    = 2'd0;
    localparam logic [1:0] REG_LOCKOUT_SECONDS = 2'd1;
    localparam logic [1:0] REG_MOTOR_SPEED     = 2'd2;

    // Configuration reset values
    localparam logic [7:0] OPEN_SECONDS_RST    = 8'd15;
    localparam logic [7:0] LOCKOUT_SECONDS_RST = 8'd60;
    localparam logic [6:0] MOTOR_SPEED_RST     = 7'd100;
    localparam logic [6:0] MOTOR_SPEED_MAX     = 7'd100;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SET1,
        PH_WAITCONF,
        PH_SET2,
        PH_CHECK,
        PH_LOCKOUT,
        PH_OPEN,
        PH_WAITMOT,
        PH_CLOSE
    } phase_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic       motion;
    } plc_in_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       alarm_on;
        logic [1:0] motor_dir;
        logic [6:0] motor_speed;
    } plc_out_t;

    typedef struct packed {
        logic [7:0] open_seconds;
        logic [7:0] lockout_seconds;
        logic [6:0] motor_speed_pct;
    } plc_cfg_t;

    // A zero tick count behaves as one tick
    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

@@ rtl/core/plc_step.sv @@
// ----------------------------------------------------------------------------
// plc_step
// Controller state and the per-beat transition logic. State moves on each
// accepted input beat; the result for that beat is produced combinationally.
// ----------------------------------------------------------------------------
module plc_step
    import plc_pkg::*;
#(
    parameter int PASS_LEN = PASS_LEN_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     beat,
    input  plc_in_t  item,
    input  plc_cfg_t cfg,
    output plc_out_t result
);

    localparam int CNT_W = $clog2(PASS_LEN + 1);
    localparam int IDX_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(PASS_LEN);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             mismatch_reg, mismatch_next;
    logic [7:0]       seconds_reg, seconds_next;
    logic [7:0]       marker_reg, marker_next;
    logic [7:0]       first_term_reg;
    logic [7:0]       stored_reg  [PASS_LEN];
    logic [7:0]       current_reg [PASS_LEN];
    logic [7:0]       first_reg   [PASS_LEN];

    logic             first_we;
    logic             term_we;
    logic             commit;        // set matched: store first entry
    logic             load_stored;   // status: current takes stored copy
    logic             tx;
    logic [7:0]       txb;
    logic [IDX_W-1:0] idx;
    logic [7:0]       ref_digit;
    logic [6:0]       speed;
    logic [1:0]       dir;

    assign idx       = count_reg[IDX_W-1:0];
    assign ref_digit = (phase_reg == PH_SET2) ? first_reg[idx] : current_reg[idx];

    // Transition for one beat
    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        mismatch_next = mismatch_reg;
        seconds_next  = seconds_reg;
        marker_next   = marker_reg;
        first_we      = 1'b0;
        term_we       = 1'b0;
        commit        = 1'b0;
        load_stored   = 1'b0;
        tx            = 1'b0;
        txb           = 8'd0;

        if (item.req_type == REQ_BYTE) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (item.rx_byte == CMD_STATUS) begin
                        tx  = 1'b1;
                        txb = marker_reg;
                        load_stored = (marker_reg == SAVED_MARK);
                    end else if (item.rx_byte == CMD_SET) begin
                        phase_next = PH_SET1;
                        count_next = '0;
                    end else if (item.rx_byte == CMD_CHECK) begin
                        phase_next    = PH_CHECK;
                        count_next    = '0;
                        mismatch_next = 1'b0;
                    end else if (item.rx_byte == CMD_LOCKOUT) begin
                        phase_next   = PH_LOCKOUT;
                        seconds_next = at_least_one(cfg.lockout_seconds);
                    end else if (item.rx_byte == CMD_UNLOCK) begin
                        phase_next   = PH_OPEN;
                        seconds_next = at_least_one(cfg.open_seconds);
                    end
                end
                PH_SET1: begin
                    if (count_reg < LAST) begin
                        first_we   = 1'b1;
                        count_next = count_reg + 1'b1;
                        tx  = 1'b1;
                        txb = ACK_DIGIT;
                    end else begin
                        term_we    = 1'b1;
                        phase_next = PH_WAITCONF;
                    end
                end
                PH_WAITCONF: begin
                    if (item.rx_byte == CMD_CONFIRM) begin
                        phase_next    = PH_SET2;
                        count_next    = '0;
                        mismatch_next = 1'b0;
                    end
                end
                PH_SET2, PH_CHECK: begin
                    tx = 1'b1;
                    if (count_reg < LAST) begin
                        if (ref_digit != item.rx_byte) mismatch_next = 1'b1;
                        count_next = count_reg + 1'b1;
                        txb = ACK_DIGIT;
                    end else begin
                        if (mismatch_reg) begin
                            txb = RSP_NOMATCH;
                        end else begin
                            txb    = RSP_MATCH;
                            commit = (phase_reg == PH_SET2);
                            if (phase_reg == PH_SET2) marker_next = first_term_reg;
                        end
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                end
                default: begin
                end
            endcase
        end else if (item.req_type == REQ_TICK) begin
            // Timed phases count down on ticks
            if (phase_reg == PH_LOCKOUT || phase_reg == PH_OPEN || phase_reg == PH_CLOSE) begin
                if (seconds_reg != 8'd0) seconds_next = seconds_reg - 8'd1;
                if (seconds_next == 8'd0) begin
                    phase_next = (phase_reg == PH_OPEN) ? PH_WAITMOT : PH_IDLE;
                end
            end
        end

        // Door clear: send lock notice and start the locking run
        if (phase_next == PH_WAITMOT && !item.motion) begin
            tx           = 1'b1;
            txb          = RSP_LOCK;
            phase_next   = PH_CLOSE;
            seconds_next = at_least_one(cfg.open_seconds);
        end
    end

    // Result drive levels
    always_comb begin
        speed = cfg.motor_speed_pct;
        if (cfg.motor_speed_pct > MOTOR_SPEED_MAX) speed = MOTOR_SPEED_MAX;
        case (phase_next)
            PH_OPEN:  dir = DIR_OPEN;
            PH_CLOSE: dir = DIR_CLOSE;
            default:  dir = DIR_STOP;
        endcase
        result.tx_valid    = tx;
        result.tx_byte     = tx ? txb : 8'd0;
        result.alarm_on    = (phase_next == PH_LOCKOUT);
        result.motor_dir   = dir;
        result.motor_speed = (dir != DIR_STOP) ? speed : 7'd0;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            count_reg    <= '0;
            mismatch_reg <= 1'b0;
            seconds_reg  <= 8'd0;
            marker_reg   <= ERASED;
        end else if (beat) begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            mismatch_reg <= mismatch_next;
            seconds_reg  <= seconds_next;
            marker_reg   <= marker_next;
        end
    end

    // Stored and current password copies
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PASS_LEN; i++) begin
                stored_reg[i]  <= ERASED;
                current_reg[i] <= 8'd0;
            end
        end else if (beat) begin
            if (commit) begin
                for (int i = 0; i < PASS_LEN; i++) begin
                    stored_reg[i]  <= first_reg[i];
                    current_reg[i] <= first_reg[i];
                end
            end else if (load_stored) begin
                for (int i = 0; i < PASS_LEN; i++) begin
                    current_reg[i] <= stored_reg[i];
                end
            end
        end
    end

    // First entry buffer, no reset
    always_ff @(posedge aclk) begin
        if (beat && first_we) first_reg[idx] <= item.rx_byte;
        if (beat && term_we)  first_term_reg <= item.rx_byte;
    end

endmodule

@@ rtl/core/plc_out_stage.sv @@
// ----------------------------------------------------------------------------
// plc_out_stage
// Result register with valid/ready handshake. Takes a new input beat
// whenever the register is empty or is being drained in the same cycle.
// ----------------------------------------------------------------------------
module plc_out_stage
    import plc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     beat,
    input  plc_out_t result,
    output logic     m_valid,
    input  logic     m_ready,
    output plc_out_t m_data
);

    logic     valid_reg;
    plc_out_t data_reg;

    assign s_ready = !valid_reg || m_ready;
    assign beat    = s_valid && s_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (beat) data_reg <= result;
    end

endmodule

@@ rtl/core/password_lock_controller_core.sv @@
// ----------------------------------------------------------------------------
// password_lock_controller_core
// Command-driven door lock: password set/check/status over serial bytes,
// timed buzzer lockout and bolt motor runs.
//
//   channel | ports                          | beat
//   --------+--------------------------------+-----------------------------
//   input   | s_valid s_ready s_data         | one byte, tick or motion item
//   result  | m_valid m_ready m_data         | one result per input beat
//   config  | cfg_valid cfg_ready cfg_addr   | one register write
//           | cfg_wdata                      |
//
// One item per cycle while s_ready is high; each result appears in the cycle after
// its input beat, set by the single result register after the transition logic.
// s_ready stays high while the result register is empty or drained that cycle.
// Reset is synchronous, active low; the block takes items on the first cycle.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module password_lock_controller_core
    import plc_pkg::*;
#(
    parameter int PASS_LEN = PASS_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  plc_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output plc_out_t   m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata
);

    plc_cfg_t cfg_reg;
    plc_out_t result;
    logic     beat;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.open_seconds    <= OPEN_SECONDS_RST;
            cfg_reg.lockout_seconds <= LOCKOUT_SECONDS_RST;
            cfg_reg.motor_speed_pct <= MOTOR_SPEED_RST;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_OPEN_SECONDS:    cfg_reg.open_seconds    <= cfg_wdata;
                REG_LOCKOUT_SECONDS: cfg_reg.lockout_seconds <= cfg_wdata;
                REG_MOTOR_SPEED:     cfg_reg.motor_speed_pct <= cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    plc_step #(
        .PASS_LEN (PASS_LEN)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat    (beat),
        .item    (s_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    plc_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .beat    (beat),
        .result  (result),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Buzzer and motor are never driven together
    a_buzz_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.alarm_on && m_data.motor_dir != DIR_STOP))
        else $error("buzzer and motor active together");

    // Speed is zero whenever the motor is stopped
    a_speed_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.motor_dir == DIR_STOP) |-> m_data.motor_speed == 7'd0)
        else $error("nonzero speed with motor stopped");

    // No reply byte without tx_valid
    a_tx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.tx_valid) |-> m_data.tx_byte == 8'd0)
        else $error("tx_byte set without tx_valid");

    // An accepted beat always yields a result next cycle
    a_beat_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted beat produced no result");

endmodule

@@ verif/lock_reply_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lock_reply_checker
// Watches the input, result and register channels of the lock controller.
// Keeps its own copy of the controller state and registers, predicts one
// result beat per input beat and compares every result, field by field,
// with the oldest prediction.
// ----------------------------------------------------------------------------
module lock_reply_checker
    import plc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  plc_in_t    s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  plc_out_t   m_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    output int         mismatch_count,
    output int         replies_pending
);

    // Register copies
    logic [7:0] open_secs;
    logic [7:0] lockout_secs;
    logic [6:0] speed_pct;

    // Controller state copy
    phase_t     phase;
    int         digit_count;
    logic [7:0] stored_digits  [PASS_LEN_DEF];
    logic [7:0] stored_marker;
    logic [7:0] current_digits [PASS_LEN_DEF];
    logic [7:0] first_entry    [PASS_LEN_DEF];
    logic [7:0] first_term;
    logic       mismatch_seen;
    logic [7:0] seconds_left;

    // Predicted result beats, oldest first
    plc_out_t   awaited_replies [$];

    // A zero count still runs for one tick
    function automatic logic [7:0] tick_count(input logic [7:0] secs);
        return (secs == 8'd0) ? 8'd1 : secs;
    endfunction

    // Advance the state copy by one input beat and return its result
    function automatic plc_out_t next_lock_reply(input plc_in_t item);
        logic       sends;
        logic [7:0] reply;
        logic [7:0] want;
        logic [6:0] speed;
        plc_out_t   res;
        sends = 1'b0;
        reply = 8'h00;
        if (item.req_type == REQ_BYTE) begin
            case (phase)
                PH_IDLE: begin
                    if (item.rx_byte == CMD_STATUS) begin
                        sends = 1'b1;
                        reply = stored_marker;
                        if (stored_marker == SAVED_MARK) current_digits = stored_digits;
                    end else if (item.rx_byte == CMD_SET) begin
                        phase       = PH_SET1;
                        digit_count = 0;
                    end else if (item.rx_byte == CMD_CHECK) begin
                        phase         = PH_CHECK;
                        digit_count   = 0;
                        mismatch_seen = 1'b0;
                    end else if (item.rx_byte == CMD_LOCKOUT) begin
                        phase        = PH_LOCKOUT;
                        seconds_left = tick_count(lockout_secs);
                    end else if (item.rx_byte == CMD_UNLOCK) begin
                        phase        = PH_OPEN;
                        seconds_left = tick_count(open_secs);
                    end
                end
                PH_SET1: begin
                    if (digit_count < PASS_LEN_DEF) begin
                        first_entry[digit_count] = item.rx_byte;
                        digit_count++;
                        sends = 1'b1;
                        reply = ACK_DIGIT;
                    end else begin
                        first_term = item.rx_byte;
                        phase      = PH_WAITCONF;
                    end
                end
                PH_WAITCONF: begin
                    if (item.rx_byte == CMD_CONFIRM) begin
                        phase         = PH_SET2;
                        digit_count   = 0;
                        mismatch_seen = 1'b0;
                    end
                end
                PH_SET2, PH_CHECK: begin
                    if (digit_count < PASS_LEN_DEF) begin
                        want = (phase == PH_SET2) ? first_entry[digit_count]
                                                  : current_digits[digit_count];
                        if (want != item.rx_byte) mismatch_seen = 1'b1;
                        digit_count++;
                        sends = 1'b1;
                        reply = ACK_DIGIT;
                    end else begin
                        // closing terminator: verdict, store on a confirmed set
                        sends = 1'b1;
                        if (mismatch_seen) begin
                            reply = RSP_NOMATCH;
                        end else begin
                            reply = RSP_MATCH;
                            if (phase == PH_SET2) begin
                                stored_digits  = first_entry;
                                stored_marker  = first_term;
                                current_digits = first_entry;
                            end
                        end
                        phase       = PH_IDLE;
                        digit_count = 0;
                    end
                end
                default: begin
                end
            endcase
        end else if (item.req_type == REQ_TICK) begin
            if (phase == PH_LOCKOUT || phase == PH_OPEN || phase == PH_CLOSE) begin
                if (seconds_left != 8'd0) seconds_left--;
                if (seconds_left == 8'd0) phase = (phase == PH_OPEN) ? PH_WAITMOT : PH_IDLE;
            end
        end

        // door clear: send the lock notice and start driving the bolt back
        if (phase == PH_WAITMOT && !item.motion) begin
            sends        = 1'b1;
            reply        = RSP_LOCK;
            phase        = PH_CLOSE;
            seconds_left = tick_count(open_secs);
        end

        speed           = (speed_pct > MOTOR_SPEED_MAX) ? MOTOR_SPEED_MAX : speed_pct;
        res.tx_valid    = sends;
        res.tx_byte     = sends ? reply : 8'h00;
        res.alarm_on    = (phase == PH_LOCKOUT);
        res.motor_dir   = (phase == PH_OPEN)  ? DIR_OPEN :
                          (phase == PH_CLOSE) ? DIR_CLOSE : DIR_STOP;
        res.motor_speed = (res.motor_dir == DIR_STOP) ? 7'd0 : speed;
        return res;
    endfunction

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Sample all channels on the rising edge
    always @(posedge aclk) begin
        plc_out_t want;
        if (!aresetn) begin
            open_secs      = OPEN_SECONDS_RST;
            lockout_secs   = LOCKOUT_SECONDS_RST;
            speed_pct      = MOTOR_SPEED_RST;
            phase          = PH_IDLE;
            digit_count    = 0;
            stored_marker  = ERASED;
            first_term     = 8'h00;
            mismatch_seen  = 1'b0;
            seconds_left   = 8'd0;
            mismatch_count = 0;
            for (int i = 0; i < PASS_LEN_DEF; i++) begin
                stored_digits[i]  = ERASED;
                current_digits[i] = 8'h00;
                first_entry[i]    = 8'h00;
            end
            awaited_replies.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_OPEN_SECONDS:    open_secs    = cfg_wdata;
                    REG_LOCKOUT_SECONDS: lockout_secs = cfg_wdata;
                    REG_MOTOR_SPEED:     speed_pct    = cfg_wdata[6:0];
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %s 0x%0h",
                             $time, "expected none, actual", m_data);
                    mismatch_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    report_field("tx_valid", want.tx_valid, m_data.tx_valid);
                    report_field("tx_byte", want.tx_byte, m_data.tx_byte);
                    report_field("alarm_on", want.alarm_on, m_data.alarm_on);
                    report_field("motor_dir", want.motor_dir, m_data.motor_dir);
                    report_field("motor_speed", want.motor_speed, m_data.motor_speed);
                end
            end
            if (s_valid && s_ready) awaited_replies.push_back(next_lock_reply(s_data));
        end
        replies_pending = awaited_replies.size();
    end

endmodule

@@ verif/password_lock_controller_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// password_lock_controller_core_test
// Drives serial bytes, ticks and motion beats into the lock controller
// under several register settings and idling patterns: a short directed
// pass, then mostly well-formed command sequences with random content plus
// noise. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module password_lock_controller_core_test;
    import plc_pkg::*;

    localparam int         STALL_LIMIT  = 2000;
    localparam int         RANDOM_ITEMS = 1200;
    localparam int         SECTIONS     = 8;
    localparam int         HOLD_CYCLES  = 150;
    localparam logic [1:0] REG_SPARE    = 2'd3;
    localparam logic [1:0] REQ_MOTION   = 2'd2;

    typedef logic [PASS_LEN_DEF-1:0][7:0] pin_t;

    logic       aclk    = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    plc_in_t    s_data;
    logic       m_valid;
    logic       m_ready = 1'b0;
    plc_out_t   m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_addr;
    logic [7:0] cfg_wdata;
    int         mismatch_count;
    int         replies_pending;

    // Stimulus knobs
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    logic       hold_off       = 1'b0;
    int         quiet_cycles   = 0;
    int         items_sent     = 0;
    logic [7:0] open_cfg;
    logic [7:0] lockout_cfg;
    pin_t       known_pin;

    // Per-section register settings and idling patterns
    logic [7:0] open_plan    [SECTIONS] = '{8'd1, 8'd2, 8'd0, 8'd4, 8'd1, 8'd3, 8'd5, 8'd2};
    logic [7:0] lockout_plan [SECTIONS] = '{8'd1, 8'd3, 8'd0, 8'd2, 8'd6, 8'd1, 8'd4, 8'd2};
    logic [7:0] speed_plan   [SECTIONS] = '{8'd0, 8'd100, 8'hFF, 8'd37,
                                            8'd101, 8'h80, 8'hE4, 8'd1};
    int         idle_plan    [4]        = '{0, 49, 0, 23};
    int         stall_plan   [4]        = '{0, 0, 49, 23};
    logic [7:0] command_pool [8]        = '{CMD_STATUS, CMD_SET, CMD_CONFIRM, CMD_CHECK,
                                            CMD_LOCKOUT, CMD_UNLOCK, ERASED, ACK_DIGIT};

    password_lock_controller_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    lock_reply_checker reply_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .replies_pending (replies_pending)
    );

    always #5 aclk = ~aclk;

    // Result side: random stalls, forced low during a hold-off
    always @(negedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("** password_lock_controller_core: FAILED **");
                $finish;
            end
        end
    end

    // One input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [1:0] kind, input logic [7:0] value,
                             input logic level);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{req_type: kind, rx_byte: value, motion: level};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] value);
        send_beat(REQ_BYTE, value, 1'($urandom_range(1)));
    endtask

    // Ticks with stray bytes mixed in; the stray bytes must be dropped
    task automatic send_ticks(input int count, input logic last_level);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)));
            send_beat(REQ_TICK, 8'($urandom_range(255)),
                      (i == count - 1) ? last_level : 1'($urandom_range(1)));
        end
    endtask

    // Five digits, one of them changed when spoil is set
    task automatic send_pin(input pin_t pin, input bit spoil);
        int slot;
        slot = spoil ? int'($urandom_range(PASS_LEN_DEF - 1)) : -1;
        for (int i = 0; i < PASS_LEN_DEF; i++)
            send_byte((i == slot) ? pin[i] ^ 8'($urandom_range(1, 255)) : pin[i]);
    endtask

    // Two entries around the confirm command, skipped bytes in between
    task automatic send_set(input bit confirm_same, input logic [7:0] terminator);
        pin_t       pin;
        logic [7:0] skip;
        for (int i = 0; i < PASS_LEN_DEF; i++) pin[i] = 8'($urandom_range(255));
        send_byte(CMD_SET);
        send_pin(pin, 1'b0);
        send_byte(terminator);
        repeat ($urandom_range(2)) begin
            skip = 8'($urandom_range(255));
            if (skip == CMD_CONFIRM) skip = ERASED;
            send_byte(skip);
        end
        send_byte(CMD_CONFIRM);
        send_pin(pin, !confirm_same);
        send_byte(8'($urandom_range(255)));
        if (confirm_same) known_pin = pin;
    endtask

    // Unlock run, motion wait of hold beats, then the locking run
    task automatic run_unlock(input int hold);
        int span;
        span = (open_cfg == 8'd0) ? 1 : int'(open_cfg);
        send_byte(CMD_UNLOCK);
        send_ticks(span, hold != 0);
        for (int i = 0; i < hold; i++)
            send_beat(2'($urandom_range(3)), 8'($urandom_range(255)), 1'b1);
        if (hold != 0) send_beat(REQ_MOTION + 2'($urandom_range(1)),
                                 8'($urandom_range(255)), 1'b0);
        send_ticks(span, 1'($urandom_range(1)));
    endtask

    task automatic run_lockout();
        send_byte(CMD_LOCKOUT);
        send_ticks((lockout_cfg == 8'd0) ? 1 : int'(lockout_cfg), 1'($urandom_range(1)));
    endtask

    // Let every predicted result arrive, then a few quiet cycles
    task automatic settle();
        s_valid <= 1'b0;
        while (replies_pending != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic reconfigure(input logic [7:0] open_s, input logic [7:0] lockout_s,
                               input logic [7:0] speed);
        settle();
        write_reg(REG_OPEN_SECONDS, open_s);
        write_reg(REG_LOCKOUT_SECONDS, lockout_s);
        write_reg(REG_MOTOR_SPEED, speed);
        open_cfg    = open_s;
        lockout_cfg = lockout_s;
    endtask

    // Mostly well-formed sequences, some noise and cut-off entries
    task automatic run_section(input int quota);
        int         stop;
        int         pick;
        logic [7:0] value;
        stop = items_sent + quota;
        while (items_sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                send_set($urandom_range(3) != 0,
                         ($urandom_range(9) < 7) ? SAVED_MARK : 8'($urandom_range(255)));
            end else if (pick < 45) begin
                send_byte(CMD_CHECK);
                send_pin(known_pin, $urandom_range(4) < 2);
                send_byte(8'($urandom_range(255)));
            end else if (pick < 53) begin
                send_byte(CMD_STATUS);
            end else if (pick < 63) begin
                run_unlock($urandom_range(3));
            end else if (pick < 70) begin
                run_lockout();
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 3)) begin
                    value = ($urandom_range(1) == 0) ? command_pool[$urandom_range(7)]
                                                     : 8'($urandom_range(255));
                    send_beat(2'($urandom_range(3)), value, 1'($urandom_range(1)));
                end
            end else begin
                // entry cut short; later bytes land as digits
                send_byte(($urandom_range(1) == 0) ? CMD_SET : CMD_CHECK);
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        known_pin   = '0;
        open_cfg    = OPEN_SECONDS_RST;
        lockout_cfg = LOCKOUT_SECONDS_RST;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: status on an erased store, erased byte in idle
        send_byte(CMD_STATUS);
        send_byte(ERASED);
        // zero counts act as one tick, speed above range saturates
        reconfigure(8'd0, 8'd0, 8'hFF);
        write_reg(REG_SPARE, 8'h5A);
        run_lockout();
        run_unlock(1);
        // saved password, then status loads it as current
        send_set(1'b1, SAVED_MARK);
        send_byte(CMD_STATUS);

        // Random sections; the first one also holds the result side off
        for (int s = 0; s < SECTIONS; s++) begin
            reconfigure(open_plan[s], lockout_plan[s], speed_plan[s]);
            send_idle_pct  = idle_plan[s % 4];
            recv_stall_pct = stall_plan[s % 4];
            if (s == 0) begin
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (HOLD_CYCLES) @(negedge aclk);
                        hold_off <= 1'b0;
                    end
                    run_section(RANDOM_ITEMS / SECTIONS);
                join
            end else begin
                run_section(RANDOM_ITEMS / SECTIONS);
            end
        end

        // Longer runs, once each
        reconfigure(8'd32, 8'd64, 8'd100);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_unlock(2);
        run_lockout();

        settle();
        if (mismatch_count == 0 && replies_pending == 0) begin
            $display("** password_lock_controller_core: PASSED **");
        end else begin
            $display("** password_lock_controller_core: FAILED **");
        end
        $finish;
    end

endmodule
